// File: rtl/core/rci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_pkg
// Shared constants and controller/datapath link types for range_crack_index.
// ----------------------------------------------------------------------------
package rci_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int MAX_CRACKS_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int IN_VAL_W  = 32;
  localparam int OPCODE_W  = 2;
  localparam int COUNT_W   = 12;
  localparam int POS_W     = 11;
  localparam int S_DATA_W  = 96;
  localparam int M_DATA_W  = 40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  // controller -> datapath
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       q_start;
    logic       loc_init;
    logic       loc_cmp;
    logic       loc_nx;
    logic       loc_end;
    logic       part_set;
    logic       p_cmp;
    logic       p_swa;
    logic       p_swb;
    logic       part_end;
    logic       add_chk;
    logic       sh_rd;
    logic       sh_wr;
    logic       ins;
    logic       out_load;
    logic [1:0] step;   // 0 locate low, 1 locate high, 2 add low, 3 add high
    logic       pstep;  // first or second partition pass
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;   // k reached crack count
    logic key_less;   // index key below search value
    logic need_next;  // exact key hit with a following entry
    logic p_done;     // partition cursor at piece end
    logic p_less;     // element below pivot
    logic p_same;     // read and write cursors equal
    logic add_skip;   // crack is redundant
    logic idx_full;
    logic sh_done;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/core/rci_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_ctrl
// Sequencer: locate both bounds, partition, then offer both cracks to index.
// ----------------------------------------------------------------------------
module rci_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rci_pkg::OPCODE_W-1:0] opcode,
  input  rci_pkg::stat_t              stat,
  output rci_pkg::cmd_t               cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_LOC_INIT = 18'h00002,
    S_LOC_RD   = 18'h00004,
    S_LOC_CMP  = 18'h00008,
    S_LOC_NX   = 18'h00010,
    S_LOC_END  = 18'h00020,
    S_PART_SET = 18'h00040,
    S_P_RD     = 18'h00080,
    S_P_CMP    = 18'h00100,
    S_P_SWA    = 18'h00200,
    S_P_SWB    = 18'h00400,
    S_PART_END = 18'h00800,
    S_ADD_CHK  = 18'h01000,
    S_SH_RD    = 18'h02000,
    S_SH_WR    = 18'h04000,
    S_INS      = 18'h08000,
    S_DONE     = 18'h10000
  } state_t;

  state_t     state, state_next;
  logic [1:0] step, step_next;
  logic       pstep, pstep_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    pstep_next = pstep;
    cmd        = '0;
    cmd.step   = step;
    cmd.pstep  = pstep;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (rci_pkg::opcode_t'(opcode))
            rci_pkg::OP_CLEAR: cmd.clear = 1'b1;
            rci_pkg::OP_LOAD:  cmd.load  = 1'b1;
            rci_pkg::OP_QUERY: begin
              cmd.q_start = 1'b1;
              step_next   = 2'd0;
              state_next  = S_LOC_INIT;
            end
            default: ;
          endcase
        end
      end
      S_LOC_INIT: begin
        cmd.loc_init = 1'b1;
        state_next   = S_LOC_RD;
      end
      S_LOC_RD: begin
        state_next = stat.scan_end ? S_LOC_END : S_LOC_CMP;
      end
      S_LOC_CMP: begin
        cmd.loc_cmp = 1'b1;
        if (stat.key_less) state_next = S_LOC_RD;
        else if (stat.need_next) state_next = S_LOC_NX;
        else state_next = S_LOC_END;
      end
      S_LOC_NX: begin
        cmd.loc_nx = 1'b1;
        state_next = S_LOC_END;
      end
      S_LOC_END: begin
        cmd.loc_end = 1'b1;
        case (step)
          2'd0: begin
            step_next  = 2'd1;
            state_next = S_LOC_INIT;
          end
          2'd1: begin
            pstep_next = 1'b0;
            state_next = S_PART_SET;
          end
          default: state_next = S_ADD_CHK;
        endcase
      end
      S_PART_SET: begin
        cmd.part_set = 1'b1;
        state_next   = S_P_RD;
      end
      S_P_RD: begin
        state_next = stat.p_done ? S_PART_END : S_P_CMP;
      end
      S_P_CMP: begin
        cmd.p_cmp  = 1'b1;
        state_next = (stat.p_less && !stat.p_same) ? S_P_SWA : S_P_RD;
      end
      S_P_SWA: begin
        cmd.p_swa  = 1'b1;
        state_next = S_P_SWB;
      end
      S_P_SWB: begin
        cmd.p_swb  = 1'b1;
        state_next = S_P_RD;
      end
      S_PART_END: begin
        cmd.part_end = 1'b1;
        if (!pstep) begin
          pstep_next = 1'b1;
          state_next = S_PART_SET;
        end else begin
          step_next  = 2'd2;
          state_next = S_LOC_INIT;
        end
      end
      S_ADD_CHK: begin
        cmd.add_chk = 1'b1;
        if (stat.add_skip || stat.idx_full) begin
          if (step == 2'd2) begin
            step_next  = 2'd3;
            state_next = S_LOC_INIT;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.sh_rd  = 1'b1;
        state_next = stat.sh_done ? S_INS : S_SH_WR;
      end
      S_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = S_SH_RD;
      end
      S_INS: begin
        cmd.ins = 1'b1;
        if (step == 2'd2) begin
          step_next  = 2'd3;
          state_next = S_LOC_INIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 2'd0;
      pstep <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      pstep <= pstep_next;
    end
  end

endmodule

// File: rtl/core/rci_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_dp
// Datapath: column memory, crack index memory, cursors and result register.
// ----------------------------------------------------------------------------
module rci_dp #(
  parameter int DEPTH       = rci_pkg::DEPTH_DEF,
  parameter int MAX_CRACKS  = rci_pkg::MAX_CRACKS_DEF,
  parameter int VALUE_WIDTH = rci_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rci_pkg::cmd_t                cmd,
  output rci_pkg::stat_t               stat,
  input  logic [rci_pkg::S_DATA_W-1:0] in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rci_pkg::M_DATA_W-1:0] out_data
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW  = $clog2(DEPTH + 1);
  localparam int CIW = (MAX_CRACKS > 1) ? $clog2(MAX_CRACKS) : 1;
  localparam int CCW = $clog2(MAX_CRACKS + 1);
  localparam int VW  = VALUE_WIDTH;
  localparam int EW  = VW + PW;
  localparam int PAD_W = rci_pkg::M_DATA_W - rci_pkg::COUNT_W - 2*rci_pkg::POS_W - 1;

  // memories
  logic [VW-1:0] col_mem [DEPTH];
  logic [EW-1:0] idx_mem [MAX_CRACKS];
  logic [VW-1:0] col_rdata;
  logic [EW-1:0] idx_rdata;
  logic [AW-1:0] col_raddr, col_waddr;
  logic [VW-1:0] col_wdata;
  logic          col_we;
  logic [CIW-1:0] idx_raddr, idx_waddr;
  logic [EW-1:0] idx_wdata;
  logic          idx_we;

  // state
  logic [PW-1:0]        ec;
  logic [CCW-1:0]       cc;
  logic signed [VW-1:0] a_val, b_val, pv, vi;
  logic [CCW-1:0]       k, j;
  logic [PW-1:0]        below_pos, hit_pos, next_pos;
  logic                 has_k, eq, has_next;
  logic [PW-1:0]        l1, r1, l2, r2, pi, pw, pr, i1, i2;
  logic                 full;
  logic [rci_pkg::M_DATA_W-1:0] out_reg;

  logic signed [VW-1:0] v, key, in_load, in_low, in_high, col_val;
  logic [PW-1:0]        pos, r_raw, r_c, l_raw, l_c, p_add;
  logic                 same;
  logic signed [PW:0]   diff;

  assign in_load = VW'($signed(in_data[rci_pkg::IN_VAL_W-1:0]));
  assign in_low  = VW'($signed(in_data[2*rci_pkg::IN_VAL_W-1:rci_pkg::IN_VAL_W]));
  assign in_high = VW'($signed(in_data[3*rci_pkg::IN_VAL_W-1:2*rci_pkg::IN_VAL_W]));

  assign v       = cmd.step[0] ? b_val : a_val;
  assign key     = $signed(idx_rdata[EW-1:PW]);
  assign pos     = idx_rdata[PW-1:0];
  assign col_val = $signed(col_rdata);
  assign same    = (l1 == l2) && (r1 == r2);
  assign p_add   = cmd.step[0] ? i2 : i1;

  // piece bounds from the last locate, clamped to the column
  always_comb begin
    if (eq) begin
      r_raw = has_next ? next_pos : ec;
      l_raw = hit_pos;
    end else begin
      r_raw = has_k ? hit_pos : ec;
      l_raw = below_pos;
    end
    r_c = (r_raw > ec) ? ec : r_raw;
    l_c = (l_raw > r_c) ? r_c : l_raw;
  end

  always_comb begin
    stat.scan_end  = (k >= cc);
    stat.key_less  = (key < v);
    stat.need_next = (key == v) && ((k + CCW'(1)) < cc);
    stat.p_done    = (pi >= pr);
    stat.p_less    = (col_val < pv);
    stat.p_same    = (pi == pw);
    stat.add_skip  = (p_add == '0) || (p_add >= ec) || (has_k && hit_pos == p_add) ||
                     ((k != '0) && below_pos == p_add) || (has_k && eq);
    stat.idx_full  = (cc >= CCW'(MAX_CRACKS));
    stat.sh_done   = (j == k);
    stat.out_busy  = out_valid && !out_ready;
  end

  // memory address and write selection
  always_comb begin
    col_raddr = cmd.p_cmp ? pw[AW-1:0] : pi[AW-1:0];
    col_we    = 1'b0;
    col_waddr = ec[AW-1:0];
    col_wdata = in_load;
    if (cmd.load && ec < PW'(DEPTH)) col_we = 1'b1;
    if (cmd.p_swa) begin
      col_we    = 1'b1;
      col_waddr = pi[AW-1:0];
      col_wdata = col_rdata;
    end
    if (cmd.p_swb) begin
      col_we    = 1'b1;
      col_waddr = pw[AW-1:0];
      col_wdata = vi;
    end
  end

  always_comb begin
    idx_raddr = k[CIW-1:0];
    if (cmd.loc_cmp) idx_raddr = CIW'(k + CCW'(1));
    if (cmd.sh_rd)   idx_raddr = CIW'(j - CCW'(1));
    idx_we    = cmd.sh_wr || cmd.ins;
    idx_waddr = cmd.ins ? k[CIW-1:0] : j[CIW-1:0];
    idx_wdata = cmd.ins ? {v, p_add} : idx_rdata;
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    col_rdata <= col_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (idx_we) idx_mem[idx_waddr] <= idx_wdata;
    idx_rdata <= idx_mem[idx_raddr];
  end

  // counts and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ec        <= '0;
      cc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        ec <= '0;
        cc <= '0;
      end
      if (cmd.load && ec < PW'(DEPTH)) ec <= ec + PW'(1);
      if (cmd.ins) cc <= cc + CCW'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign diff = $signed({1'b0, i2}) - $signed({1'b0, i1});

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      a_val <= in_low;
      b_val <= in_high;
      full  <= 1'b0;
    end
    if (cmd.loc_init) begin
      k         <= '0;
      below_pos <= '0;
      has_k     <= 1'b0;
      eq        <= 1'b0;
      has_next  <= 1'b0;
    end
    if (cmd.loc_cmp) begin
      if (key < v) begin
        below_pos <= pos;
        k         <= k + CCW'(1);
      end else begin
        has_k    <= 1'b1;
        hit_pos  <= pos;
        eq       <= (key == v);
        has_next <= (key == v) && ((k + CCW'(1)) < cc);
      end
    end
    if (cmd.loc_nx) next_pos <= pos;
    if (cmd.loc_end && !cmd.step[1]) begin
      if (!cmd.step[0]) begin
        l1 <= l_c;
        r1 <= r_c;
      end else begin
        l2 <= l_c;
        r2 <= r_c;
      end
    end
    if (cmd.part_set) begin
      // both bounds inside one piece: split on high first, then low below it
      if (!cmd.pstep) begin
        pv <= same ? b_val : a_val;
        pi <= l1;
        pw <= l1;
        pr <= r1;
      end else if (same) begin
        pv <= a_val;
        pi <= l1;
        pw <= l1;
        pr <= i2;
      end else begin
        pv <= b_val;
        pi <= l2;
        pw <= l2;
        pr <= r2;
      end
    end
    if (cmd.p_cmp) begin
      vi <= col_val;
      if (!(col_val < pv)) begin
        pi <= pi + PW'(1);
      end else if (pi == pw) begin
        pi <= pi + PW'(1);
        pw <= pw + PW'(1);
      end
    end
    if (cmd.p_swb) begin
      pi <= pi + PW'(1);
      pw <= pw + PW'(1);
    end
    if (cmd.part_end) begin
      if (same == cmd.pstep) i1 <= pw;
      else i2 <= pw;
    end
    if (cmd.add_chk) begin
      if (!stat.add_skip && stat.idx_full) full <= 1'b1;
      if (!stat.add_skip && !stat.idx_full) j <= cc;
    end
    if (cmd.sh_wr) j <= j - CCW'(1);
    if (cmd.out_load) begin
      out_reg <= {{PAD_W{1'b0}}, full, rci_pkg::POS_W'(i2), rci_pkg::POS_W'(i1),
                  rci_pkg::COUNT_W'(diff)};
    end
  end

  assign out_data = out_reg;

  a_ec_bound: assert property (@(posedge clk) disable iff (rst) ec <= PW'(DEPTH))
    else $error("element count above depth");
  a_cc_bound: assert property (@(posedge clk) disable iff (rst) cc <= CCW'(MAX_CRACKS))
    else $error("crack count above capacity");
  a_cursor: assert property (@(posedge clk) disable iff (rst) cmd.p_cmp |-> (pw <= pi && pi < pr))
    else $error("partition cursors out of order");
  a_result: assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("result not presented");

endmodule

// File: rtl/core/range_crack_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_crack_index
// Adaptive range select over a column with a sorted crack index.
// ----------------------------------------------------------------------------
// Channel   Dir  Word contents
// s_axis    in   tuser: opcode; tdata: load_value, range_low, range_high
// m_axis    out  tdata: qualified_count, low_position, high_position, index_full
//
// Clear and load are handled in idle. A query scans the index four times,
// partitions the pieces element by element (single column memory port),
// and shifts index entries on insert. Reset is synchronous; memories are
// not cleared.
// A held result blocks only the end of the next query.
// ----------------------------------------------------------------------------
module range_crack_index #(
  parameter int DEPTH       = rci_pkg::DEPTH_DEF,
  parameter int MAX_CRACKS  = rci_pkg::MAX_CRACKS_DEF,
  parameter int VALUE_WIDTH = rci_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rci_pkg::S_DATA_W-1:0]  s_axis_tdata,  // load_value, range_low, range_high
  input  logic [rci_pkg::OPCODE_W-1:0]  s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rci_pkg::M_DATA_W-1:0]  m_axis_tdata   // count, low, high, full, pad
);

  rci_pkg::cmd_t  cmd;
  rci_pkg::stat_t stat;

  rci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .opcode   (s_axis_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  rci_dp #(
    .DEPTH       (DEPTH),
    .MAX_CRACKS  (MAX_CRACKS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
